@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/ppst_pkg.sv @@
// Shared widths, codes and tables of the peer penalty score table.
`timescale 1ns / 1ps

package ppst_pkg;

  localparam int ScoreW   = 31;
  localparam int TimeW    = 48;
  localparam int ThrW     = 20;
  localparam int RateW    = 14;
  localparam int OpW      = 2;
  localparam int PeerIdxW = 8;
  localparam int CodeW    = 4;
  localparam int WeightW  = 7;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 20;
  localparam int RemW     = 16;

  localparam int NumPeersDef = 256;

  localparam logic [RemW-1:0]   MsPerMinute = 16'd60000;
  localparam logic [ScoreW-1:0] ScoreMax    = '1;
  localparam logic [ThrW-1:0]   ThrReset    = 20'd100;
  localparam logic [RateW-1:0]  RateReset   = 14'd1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBanThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDecayRate    = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpOffence = 2'd0,
    OpGood    = 2'd1,
    OpReset   = 2'd2,
    OpIgnore  = 2'd3
  } op_e;

  // offence codes, grouped by weight class
  localparam logic [CodeW-1:0] OffTimeout = 4'd1;
  localparam logic [CodeW-1:0] OffMinorLo = 4'd2;
  localparam logic [CodeW-1:0] OffMinorHi = 4'd4;
  localparam logic [CodeW-1:0] OffMidLo   = 4'd5;
  localparam logic [CodeW-1:0] OffMidHi   = 4'd6;
  localparam logic [CodeW-1:0] OffMajorLo = 4'd7;
  localparam logic [CodeW-1:0] OffMajorHi = 4'd8;
  localparam logic [CodeW-1:0] OffSevereLo = 4'd9;
  localparam logic [CodeW-1:0] OffSevereHi = 4'd11;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [WeightW-1:0] offence_weight(input logic [CodeW-1:0] code);
    logic [WeightW-1:0] w;
    case (code) inside
      OffTimeout:                 w = 7'd5;
      [OffMinorLo:OffMinorHi]:    w = 7'd10;
      [OffMidLo:OffMidHi]:        w = 7'd20;
      [OffMajorLo:OffMajorHi]:    w = 7'd50;
      [OffSevereLo:OffSevereHi]:  w = 7'd100;
      default:                    w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/ppst_if.sv @@
// Valid/ready channel interfaces for events and results.
`timescale 1ns / 1ps

interface ppst_in_if import ppst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      operation;
  logic [PeerIdxW-1:0] peer_index;
  logic [CodeW-1:0]    offence_code;
  logic [TimeW-1:0]    time_ms;

  modport source (output valid, operation, peer_index, offence_code, time_ms, input ready);
  modport sink (input valid, operation, peer_index, offence_code, time_ms, output ready);
endinterface

interface ppst_out_if import ppst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ScoreW-1:0] score;
  logic              ban;

  modport source (output valid, score, ban, input ready);
  modport sink (input valid, score, ban, output ready);
endinterface

@@ rtl/peer_penalty_score_table_core.sv @@
// Top level: per-peer penalty score table with decay and ban flag.
`timescale 1ns / 1ps
// Usage:
//   evt_i carries events (operation, peer_index, offence_code, time_ms);
//   res_o returns one beat per event: the peer's score after it and ban.
//   cfg_we_i/cfg_idx_i/cfg_data_i write ban_threshold (index 0) and
//   decay_rate (index 1); write them only while no event is in flight.
// Flow:
//   One event at a time. An out-of-range peer skips the table lookup
//   that all other events pass; a good interaction that reaches the
//   divider waits for it, then decays the score in a further step,
//   skipped when under a minute has passed or the minute count alone
//   clears the score: the shared multiplier turns elapsed ms into
//   whole minutes by reciprocal multiply in four steps.
// Reset:
//   After rst_ni the table is swept to zero, one entry per cycle, through
//   all NUM_PEERS entries; evt_i.ready stays low during the sweep.
// Stall:
//   A finished result sits in the output register; one more event is
//   accepted and worked on while it waits, then the block holds until
//   res_o.ready takes the earlier beat.

module peer_penalty_score_table_core import ppst_pkg::*; #(
  parameter int NUM_PEERS = NumPeersDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppst_in_if.sink             evt_i,
  ppst_out_if.source          res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW  = $clog2(NUM_PEERS);
  localparam int ExtW  = (IdxW > PeerIdxW) ? IdxW : PeerIdxW;
  localparam int ProdW = ScoreW + RateW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_PEERS - 1);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StLook  = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [ThrW-1:0]  thr_q;
  logic [RateW-1:0] rate_q;

  // event held while it is worked on
  op_e              op_q;
  logic [CodeW-1:0] code_q;
  logic [TimeW-1:0] time_q;
  logic [IdxW-1:0]  addr_q;
  logic             in_range_q, in_range_d;

  // table and its read port
  logic [ScoreW-1:0] score_mem  [NUM_PEERS];
  logic [TimeW-1:0]  anchor_mem [NUM_PEERS];
  logic [ScoreW-1:0] rd_score_q;
  logic [TimeW-1:0]  rd_anchor_q;
  logic [ExtW-1:0]   idx_ext;
  logic [IdxW-1:0]   rd_addr;
  logic              idx_ok;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [ScoreW-1:0] mem_wscore;
  logic [TimeW-1:0]  mem_wanchor;

  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;

  logic [ScoreW-1:0] res_q, res_d;
  logic [ProdW-1:0]  prod_q, prod_d;

  logic              out_valid_q, out_valid_d;
  logic [ScoreW-1:0] out_score_q;
  logic              out_ban_q;
  logic              load_out;

  logic in_acc;

  // arithmetic for the current entry
  logic [ScoreW:0]    sum;
  logic [ScoreW-1:0]  sat_sum;
  logic [TimeW-1:0]   elapsed;
  logic               reanchor;
  logic               div_start;
  logic [TimeW-1:0]   quot;
  div_stat_t          div_stat;

  assign evt_i.ready = (state_q == StIdle);
  assign in_acc      = evt_i.valid && evt_i.ready;

  assign idx_ext = ExtW'(evt_i.peer_index);
  assign rd_addr = idx_ext[IdxW-1:0];
  assign idx_ok  = ({1'b0, idx_ext} < (ExtW + 1)'(NUM_PEERS));

  assign sum      = (ScoreW + 1)'(rd_score_q) + (ScoreW + 1)'(offence_weight(code_q));
  assign sat_sum  = sum[ScoreW] ? ScoreMax : sum[ScoreW-1:0];
  assign elapsed  = time_q - rd_anchor_q;
  assign reanchor = (rd_score_q == '0) || (rate_q == '0) || (rd_anchor_q == '0)
                    || (time_q <= rd_anchor_q);

  ppst_minute_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  assign load_out = (state_q == StDone) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    in_range_d  = in_range_q;
    res_d       = res_q;
    prod_d      = prod_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wscore  = rd_score_q;
    mem_wanchor = rd_anchor_q;
    div_start   = 1'b0;
    unique case (state_q)
      StClear: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_q;
        mem_wscore  = '0;
        mem_wanchor = '0;
        clr_cnt_d   = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          in_range_d = idx_ok;
          res_d      = '0;
          state_d    = idx_ok ? StLook : StDone;
        end
      end
      StLook: begin
        res_d   = rd_score_q;
        state_d = StDone;
        case (op_q)
          OpOffence: begin
            mem_we     = 1'b1;
            mem_wscore = sat_sum;
            res_d      = sat_sum;
          end
          OpGood: begin
            if (reanchor) begin
              mem_we      = 1'b1;
              mem_wanchor = time_q;
            end else begin
              div_start = 1'b1;
              state_d   = StDiv;
            end
          end
          OpReset: begin
            mem_we      = 1'b1;
            mem_wscore  = '0;
            mem_wanchor = time_q;
            res_d       = '0;
          end
          default: ;
        endcase
      end
      StDiv: begin
        if (div_stat.done) begin
          if (quot == '0) begin
            // under a minute: leave the anchor so fractions add up
            state_d = StDone;
          end else if (quot[TimeW-1:ScoreW] != '0) begin
            mem_we      = 1'b1;
            mem_wscore  = '0;
            mem_wanchor = time_q;
            res_d       = '0;
            state_d     = StDone;
          end else begin
            prod_d  = ProdW'(quot[ScoreW-1:0]) * ProdW'(rate_q);
            state_d = StMul;
          end
        end
      end
      StMul: begin
        mem_we      = 1'b1;
        mem_wanchor = time_q;
        if (prod_q >= ProdW'(rd_score_q)) begin
          mem_wscore = '0;
        end else begin
          mem_wscore = rd_score_q - prod_q[ScoreW-1:0];
        end
        res_d   = mem_wscore;
        state_d = StDone;
      end
      StDone: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      in_range_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      in_range_q  <= in_range_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrReset;
      rate_q <= RateReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBanThreshold: thr_q  <= cfg_data_i[ThrW-1:0];
        CfgDecayRate:    rate_q <= cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(evt_i.operation);
      code_q <= evt_i.offence_code;
      time_q <= evt_i.time_ms;
      addr_q <= rd_addr;
    end
    res_q  <= res_d;
    prod_q <= prod_d;
    if (load_out) begin
      out_score_q <= res_q;
      out_ban_q   <= in_range_q && (res_q >= ScoreW'(thr_q));
    end
  end

  // table storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      score_mem[mem_waddr]  <= mem_wscore;
      anchor_mem[mem_waddr] <= mem_wanchor;
    end
    if (in_acc) begin
      rd_score_q  <= score_mem[rd_addr];
      rd_anchor_q <= anchor_mem[rd_addr];
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.score = out_score_q;
  assign res_o.ban   = out_ban_q;

endmodule

@@ rtl/ppst_minute_div.sv @@
// Minute divider: elapsed ms to whole minutes by reciprocal multiply on one shared multiplier.
`timescale 1ns / 1ps

module ppst_minute_div import ppst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  output logic [TimeW-1:0] quotient_o,
  output div_stat_t        stat_o
);

  // one minute is 1875 << 5 ms: drop the five low bits, then multiply by
  // ceil(2^54 / 1875), which is exact for every 43-bit value
  localparam int PreShift  = 5;
  localparam int XW        = TimeW - PreShift;
  localparam int ChunkW    = 11;
  localparam int NumChunks = 4;
  localparam int RecipW    = ChunkW * NumChunks;
  localparam int QShift    = 54;
  localparam int AccW      = XW + RecipW;
  localparam int PpW       = XW + ChunkW;
  localparam int CntW      = $clog2(NumChunks);
  localparam logic [RecipW-1:0] Recip    = 44'd9607679205058;
  localparam logic [CntW-1:0]   LastStep = CntW'(NumChunks - 1);

  logic [XW-1:0]     x_q, x_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ChunkW-1:0] chunk;
  logic [PpW-1:0]    pp;

  // walk the reciprocal from its top chunk down
  always_comb begin
    unique case (cnt_q)
      2'd0:    chunk = Recip[RecipW-1 -: ChunkW];
      2'd1:    chunk = Recip[3*ChunkW-1 -: ChunkW];
      2'd2:    chunk = Recip[2*ChunkW-1 -: ChunkW];
      default: chunk = Recip[ChunkW-1:0];
    endcase
  end

  assign pp = PpW'(x_q) * PpW'(chunk);

  always_comb begin
    x_d    = x_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = dividend_i[TimeW-1:PreShift];
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift the partial sum up one chunk and add the next product
      acc_d = (acc_q << ChunkW) + AccW'(pp);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
  end

  assign quotient_o  = TimeW'(acc_q[AccW-1:QShift]);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/ppst_checker.sv @@
// Port-level checks of the peer penalty score table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppst_checker import ppst_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [ScoreW-1:0] out_score_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // events accepted whose result beat has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni && $past(!rst_ni) |-> !in_ready_i && !out_valid_i,
                 "active in reset")
  `ASSERT_CLK(a_busy_after_accept, in_acc |=> !in_ready_i, "ready right after an accept")
  `ASSERT_CLK(a_no_extra_result, out_valid_i |-> pend_q != 2'd0, "result with no event")
  `ASSERT_CLK(a_one_waiting, in_acc |-> pend_q != 2'd2, "accept with two events pending")
  `ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i),
              "stalled result beat changed")

endmodule

bind peer_penalty_score_table_core ppst_checker u_ppst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (evt_i.valid),
  .in_ready_i  (evt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_score_i (res_o.score)
);
